// ----- rtl/mkc_pkg.sv -----
// ---------------------------------------------------------------------------
// mkc_pkg
// shared types and constants for the multi-key lfu cache
// ---------------------------------------------------------------------------
`default_nettype none
package mkc_pkg;
   localparam int unsigned KEY_W = 32;
   localparam int unsigned SIG_W = 24;
   localparam int unsigned CNT_W = 32;
   localparam int unsigned REQ_DATA_W = 216;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_DATA_W = 128;
   localparam int unsigned RSP_USER_W = 1;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } stat_type;
endpackage
`default_nettype wire

// ----- rtl/mkc_ctrl.sv -----
// ---------------------------------------------------------------------------
// mkc_ctrl
// sequencer: accept, scan every entry, apply, hand the result word out
// ---------------------------------------------------------------------------
`default_nettype none
module mkc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire mkc_pkg::stat_type  stat,
   output mkc_pkg::cmd_type        cmd
);
   mkc_pkg::state_type state_ff, state_in;
   logic valid_ff, valid_in;
   logic out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mkc_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      valid_in   = valid_ff && !rsp_tready;
      unique case (state_ff)
         mkc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = mkc_pkg::ST_SCAN;
            end
         end
         mkc_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
            if (stat.scan_last) state_in = mkc_pkg::ST_APPLY;
         end
         mkc_pkg::ST_APPLY: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               valid_in   = 1'b1;
               state_in   = mkc_pkg::ST_IDLE;
            end
         end
         default: state_in = mkc_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/mkc_dpath.sv -----
// ---------------------------------------------------------------------------
// mkc_dpath
// entry storage, one-entry-per-cycle scan, commit of updates, result register
// ---------------------------------------------------------------------------
`default_nettype none
module mkc_dpath #(
   parameter int unsigned ENTRIES = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [mkc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [mkc_pkg::REQ_USER_W-1:0]    req_tuser,
   input  wire mkc_pkg::cmd_type                  cmd,
   output mkc_pkg::stat_type                      stat,
   output logic [mkc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [mkc_pkg::RSP_USER_W-1:0]         rsp_tuser
);
   localparam int unsigned IW = $clog2(ENTRIES);
   localparam int unsigned KW = mkc_pkg::KEY_W;
   localparam int unsigned SW = mkc_pkg::SIG_W;
   localparam int unsigned CW = mkc_pkg::CNT_W;

   logic [KW-1:0] kp_ff [ENTRIES];
   logic [KW-1:0] ks_ff [ENTRIES];
   logic [KW-1:0] km_ff [ENTRIES];
   logic [KW-1:0] kd_ff [ENTRIES];
   logic [SW-1:0] ksig_ff [ENTRIES];
   logic [KW-1:0] info_ff [ENTRIES];
   logic [KW-1:0] ops_ff [ENTRIES];
   logic [CW-1:0] cnt_ff [ENTRIES];
   logic [CW-1:0] stm_ff [ENTRIES];
   logic [CW-1:0] cs_ff, hits_ff, miss_ff;

   // latched request
   mkc_pkg::op_type op_ff;
   logic [KW-1:0] p_ff, s_ff, m_ff, d_ff, ih_ff, oh_ff;
   logic [SW-1:0] sig_ff;
   logic          sg_ff;

   // scan results
   logic [IW-1:0] idx_ff;
   logic          fh_ff, fr_ff, fe_ff;
   logic [IW-1:0] hit_ff, rm_ff, emp_ff, best_ff;
   logic [CW-1:0] minc_ff, mint_ff;

   logic [KW-1:0] e_p, e_s, e_m, e_d;
   logic [SW-1:0] e_sig;
   logic [CW-1:0] e_cnt, e_stm;
   logic          e_hit;
   logic [IW-1:0] vic;
   logic [CW-1:0] hits_in, miss_in;

   assign e_p   = kp_ff[idx_ff];
   assign e_s   = ks_ff[idx_ff];
   assign e_m   = km_ff[idx_ff];
   assign e_d   = kd_ff[idx_ff];
   assign e_sig = ksig_ff[idx_ff];
   assign e_cnt = cnt_ff[idx_ff];
   assign e_stm = stm_ff[idx_ff];
   assign e_hit = (e_p != '0) &&
                  ((p_ff != '0 && e_p == p_ff) || (s_ff != '0 && e_s == s_ff) ||
                   (m_ff != '0 && e_m == m_ff) || (d_ff != '0 && e_d == d_ff) ||
                   (sg_ff && e_sig[SW-1:SW-8] != '0 && e_sig == sig_ff));
   assign stat.scan_last = (idx_ff == IW'(ENTRIES - 1));
   assign vic = fe_ff ? emp_ff : best_ff;

   always_comb begin
      hits_in = hits_ff;
      miss_in = miss_ff;
      if (op_ff == mkc_pkg::OP_LOOKUP) begin
         if (fh_ff) hits_in = hits_ff + 1'b1;
         else       miss_in = miss_ff + 1'b1;
      end else if (op_ff == mkc_pkg::OP_CLEAR) begin
         hits_in = '0;
         miss_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= mkc_pkg::op_type'(req_tuser[1:0]);
         sg_ff  <= req_tuser[2];
         p_ff   <= req_tdata[31:0];
         s_ff   <= req_tdata[63:32];
         m_ff   <= req_tdata[95:64];
         d_ff   <= req_tdata[127:96];
         sig_ff <= req_tdata[151:128];
         ih_ff  <= req_tdata[183:152];
         oh_ff  <= req_tdata[215:184];
         idx_ff <= '0;
         fh_ff  <= 1'b0;
         fr_ff  <= 1'b0;
         fe_ff  <= 1'b0;
      end else if (cmd.step) begin
         if (!stat.scan_last) idx_ff <= idx_ff + 1'b1;
         if (!fh_ff && e_hit) begin
            fh_ff  <= 1'b1;
            hit_ff <= idx_ff;
         end
         if (!fr_ff && e_p == p_ff) begin
            fr_ff <= 1'b1;
            rm_ff <= idx_ff;
         end
         if (idx_ff == '0) begin
            best_ff <= '0;
            minc_ff <= e_cnt;
            mint_ff <= e_stm;
         end else if (!fe_ff) begin
            if (e_p == '0) begin
               fe_ff  <= 1'b1;
               emp_ff <= idx_ff;
            end else if (e_cnt < minc_ff || (e_cnt == minc_ff && e_stm < mint_ff)) begin
               best_ff <= idx_ff;
               minc_ff <= e_cnt;
               mint_ff <= e_stm;
            end
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_tdata[31:0]   <= (op_ff == mkc_pkg::OP_LOOKUP && fh_ff) ? info_ff[hit_ff] : '0;
         rsp_tdata[63:32]  <= (op_ff == mkc_pkg::OP_LOOKUP && fh_ff) ? ops_ff[hit_ff] : '0;
         rsp_tdata[95:64]  <= hits_in;
         rsp_tdata[127:96] <= miss_in;
         rsp_tuser[0]      <= (op_ff == mkc_pkg::OP_LOOKUP && !fh_ff) ||
                              (op_ff == mkc_pkg::OP_REMOVE && !fr_ff);
      end
   end

   // entry storage and global counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff   <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
         for (int j = 0; j < ENTRIES; j++) begin
            kp_ff[j] <= '0; ks_ff[j] <= '0; km_ff[j] <= '0; kd_ff[j] <= '0;
            ksig_ff[j] <= '0; info_ff[j] <= '0; ops_ff[j] <= '0;
            cnt_ff[j] <= '0; stm_ff[j] <= '0;
         end
      end else if (cmd.commit) begin
         hits_ff <= hits_in;
         miss_ff <= miss_in;
         case (op_ff)
            mkc_pkg::OP_ADD: begin
               cs_ff <= cs_ff + 1'b1;
               if (fh_ff) begin
                  info_ff[hit_ff] <= ih_ff;
                  ops_ff[hit_ff]  <= oh_ff;
                  cnt_ff[hit_ff]  <= cnt_ff[hit_ff] + 1'b1;
                  stm_ff[hit_ff]  <= cs_ff;
               end else begin
                  kp_ff[vic]   <= p_ff;
                  ks_ff[vic]   <= s_ff;
                  km_ff[vic]   <= m_ff;
                  kd_ff[vic]   <= d_ff;
                  ksig_ff[vic] <= sg_ff ? sig_ff : '0;
                  info_ff[vic] <= ih_ff;
                  ops_ff[vic]  <= oh_ff;
                  cnt_ff[vic]  <= CW'(1);
                  stm_ff[vic]  <= cs_ff;
               end
            end
            mkc_pkg::OP_LOOKUP: begin
               if (fh_ff) begin
                  cs_ff          <= cs_ff + 1'b1;
                  cnt_ff[hit_ff] <= cnt_ff[hit_ff] + 1'b1;
                  stm_ff[hit_ff] <= cs_ff;
               end
            end
            mkc_pkg::OP_REMOVE: begin
               if (fr_ff) begin
                  kp_ff[rm_ff] <= '0; ks_ff[rm_ff] <= '0; km_ff[rm_ff] <= '0;
                  kd_ff[rm_ff] <= '0; ksig_ff[rm_ff] <= '0; info_ff[rm_ff] <= '0;
                  ops_ff[rm_ff] <= '0; cnt_ff[rm_ff] <= '0; stm_ff[rm_ff] <= '0;
               end
            end
            default: begin
               cs_ff <= '0;
               for (int j = 0; j < ENTRIES; j++) begin
                  kp_ff[j] <= '0; ks_ff[j] <= '0; km_ff[j] <= '0; kd_ff[j] <= '0;
                  ksig_ff[j] <= '0; info_ff[j] <= '0; ops_ff[j] <= '0;
                  cnt_ff[j] <= '0; stm_ff[j] <= '0;
               end
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- rtl/multi_key_cache_lfu_replace.sv -----
// ---------------------------------------------------------------------------
// multi_key_cache_lfu_replace
// fully associative multi-key table with least-frequently-used replacement
// ---------------------------------------------------------------------------
// requests are handled one at a time: the entry scan reads one entry per cycle
//   through a single read mux, and a new request is taken only after the
//   previous one is committed to its result word
// the next request is taken while the previous result word still waits
// reset: synchronous, clears every entry, the stamp clock and both totals
`default_nettype none
module multi_key_cache_lfu_replace #(
   parameter int unsigned ENTRIES = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // primary_id, scan_id, memory_id, part_id, sig_bytes, info_handle_in, ops_handle_in
   input  wire logic [215:0]  req_tdata,
   // operation, sig_given
   input  wire logic [2:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // info_handle_out, ops_handle_out, hit_total, miss_total
   output logic [127:0]       rsp_tdata,
   // status
   output logic [0:0]         rsp_tuser
);
   mkc_pkg::cmd_type  cmd;
   mkc_pkg::stat_type stat;

   // sequencer
   mkc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // storage, scan and result register
   mkc_dpath #(.ENTRIES(ENTRIES)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // a committed item always presents a result word next cycle
   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid) else $error("commit without result word");

   // never overwrite a result word that is still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready)) else $error("result overrun");

   // an accepted word starts the scan, no second accept next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("double accept");
endmodule
`default_nettype wire

// ----- sim/mkc_checker.sv -----
// ---------------------------------------------------------------------------
// mkc_checker
// watches the request and response streams of the multi-key lfu cache,
// keeps its own copy of the table and compares every response word
// ---------------------------------------------------------------------------
module mkc_checker #(
   parameter int unsigned ENTRIES = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [215:0] req_tdata,
   input  wire logic [2:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   input  wire logic [0:0]   rsp_tuser,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        status;
      logic [31:0] info;
      logic [31:0] ops;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } answer_type;

   logic [31:0] t_pri [ENTRIES];
   logic [31:0] t_scan[ENTRIES];
   logic [31:0] t_mem [ENTRIES];
   logic [31:0] t_part[ENTRIES];
   logic [23:0] t_sig [ENTRIES];
   logic [31:0] t_info[ENTRIES];
   logic [31:0] t_ops [ENTRIES];
   logic [31:0] t_cnt [ENTRIES];
   logic [31:0] t_stmp[ENTRIES];
   logic [31:0] now_stamp, hit_cnt, miss_cnt;
   answer_type  answers[$];

   function automatic void wipe(int i);
      t_pri[i] = 0; t_scan[i] = 0; t_mem[i] = 0; t_part[i] = 0; t_sig[i] = 0;
      t_info[i] = 0; t_ops[i] = 0; t_cnt[i] = 0; t_stmp[i] = 0;
   endfunction

   function automatic void wipe_all();
      for (int i = 0; i < ENTRIES; i++) wipe(i);
      now_stamp = 0; hit_cnt = 0; miss_cnt = 0;
   endfunction

   function automatic int match_slot(logic [31:0] p, s, m, d, logic [23:0] sg, logic sg_on);
      for (int i = 0; i < ENTRIES; i++) begin
         if (t_pri[i] == 0) continue;
         if ((p != 0 && t_pri[i] == p) || (s != 0 && t_scan[i] == s) ||
             (m != 0 && t_mem[i] == m) || (d != 0 && t_part[i] == d) ||
             (sg_on && t_sig[i][23:16] != 0 && t_sig[i] == sg))
            return i;
      end
      return ENTRIES;
   endfunction

   function automatic int pick_victim();
      int best;
      logic [31:0] lo_cnt, lo_t;
      best = 0; lo_cnt = t_cnt[0]; lo_t = t_stmp[0];
      for (int i = 1; i < ENTRIES; i++) begin
         if (t_pri[i] == 0) return i;
         if (t_cnt[i] < lo_cnt || (t_cnt[i] == lo_cnt && t_stmp[i] < lo_t)) begin
            lo_cnt = t_cnt[i]; lo_t = t_stmp[i]; best = i;
         end
      end
      return best;
   endfunction

   function automatic answer_type apply_word(logic [215:0] d, logic [2:0] u);
      answer_type a;
      mkc_pkg::op_type op;
      logic [31:0] p, s, m, pt, ii, oi;
      logic [23:0] sg;
      logic sg_on;
      int idx;
      op = mkc_pkg::op_type'(u[1:0]); sg_on = u[2];
      p = d[31:0]; s = d[63:32]; m = d[95:64]; pt = d[127:96];
      sg = d[151:128]; ii = d[183:152]; oi = d[215:184];
      a = '0;
      case (op)
         mkc_pkg::OP_ADD: begin
            idx = match_slot(p, s, m, pt, sg, sg_on);
            if (idx < ENTRIES) t_cnt[idx] = t_cnt[idx] + 1;
            else begin
               idx = pick_victim();
               t_pri[idx] = p; t_scan[idx] = s; t_mem[idx] = m; t_part[idx] = pt;
               t_sig[idx] = sg_on ? sg : 24'd0; t_cnt[idx] = 1;
            end
            t_info[idx] = ii; t_ops[idx] = oi;
            t_stmp[idx] = now_stamp; now_stamp = now_stamp + 1;
         end
         mkc_pkg::OP_LOOKUP: begin
            idx = match_slot(p, s, m, pt, sg, sg_on);
            if (idx < ENTRIES) begin
               t_cnt[idx] = t_cnt[idx] + 1;
               t_stmp[idx] = now_stamp; now_stamp = now_stamp + 1;
               a.info = t_info[idx]; a.ops = t_ops[idx];
               hit_cnt = hit_cnt + 1;
            end else begin
               miss_cnt = miss_cnt + 1; a.status = 1;
            end
         end
         mkc_pkg::OP_REMOVE: begin
            a.status = 1;
            for (int i = 0; i < ENTRIES; i++)
               if (t_pri[i] == p) begin
                  wipe(i); a.status = 0; break;
               end
         end
         default: wipe_all();
      endcase
      a.hit_total = hit_cnt; a.miss_total = miss_cnt;
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         wipe_all();
         answers.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) answers.push_back(apply_word(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[63:32],
                   rsp_tdata[95:64], rsp_tdata[127:96]};
            if (answers.size() == 0) begin
               if (fail_count < 10) $display("unexpected response word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (want != got) begin
                  if (fail_count < 10)
                     $display("response mismatch: expected st=%0d info=%h ops=%h hit=%0d miss=%0d, got st=%0d info=%h ops=%h hit=%0d miss=%0d",
                              want.status, want.info, want.ops, want.hit_total, want.miss_total,
                              got.status, got.info, got.ops, got.hit_total, got.miss_total);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= answers.size();
   end
endmodule

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// stimulus for the multi-key lfu cache: directed words first, then random
// add / lookup / remove / clear traffic over a small key pool so hits, evictions and
// signature matches are common; the checker beside the block judges results
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ENTRIES = 32;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [215:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   int           fail_count;
   int           pending;
   bit           stall_rsp = 0;

   always #5 clock = ~clock;

   multi_key_cache_lfu_replace #(.ENTRIES(ENTRIES)) DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   mkc_checker #(.ENTRIES(ENTRIES)) checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .fail_count, .pending
   );

   // receiver: phases of mostly-ready random accept and long stalls with rare accepts
   always @(posedge clock) begin
      int mode;
      mode = $urandom_range(0, 99);
      if (stall_rsp) rsp_tready <= (mode < 5);
      else rsp_tready <= (mode < 70);
   end

   initial begin
      forever begin
         repeat ($urandom_range(200, 2000)) @(posedge clock);
         stall_rsp = ~stall_rsp;
      end
   end

   // small key pool so queries collide with stored entries
   function automatic logic [31:0] pick_key(int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 32'd0;
      if (r < 90) return 32'd1 + $urandom_range(0, 47);
      return $urandom();
   endfunction

   // one request word, held until accepted; bursts broken by random gaps
   task automatic send_word(mkc_pkg::op_type op, logic [31:0] p, s, m, d,
                            logic [23:0] sg, logic sg_on, logic [31:0] ii, oi);
      req_tdata  <= {oi, ii, sg, d, m, s, p};
      req_tuser  <= {sg_on, op};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   endtask

   task automatic random_word();
      int r;
      mkc_pkg::op_type op;
      logic [23:0] sg;
      r = $urandom_range(0, 99);
      if (r < 45) op = mkc_pkg::OP_ADD;
      else if (r < 80) op = mkc_pkg::OP_LOOKUP;
      else if (r < 99) op = mkc_pkg::OP_REMOVE;
      else op = mkc_pkg::OP_CLEAR;
      sg = ($urandom_range(0, 1)) ? {8'd1 + 8'($urandom_range(0, 3)), 16'h00AA} : 24'($urandom());
      send_word(op, pick_key(op == mkc_pkg::OP_ADD ? 5 : 30), pick_key(60), pick_key(60),
                pick_key(60), sg, 1'($urandom()), $urandom(), $urandom());
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, every operation, signature rules, zero keys
      send_word(mkc_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(mkc_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(mkc_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 32'h1, 32'h2);
      send_word(mkc_pkg::OP_ADD, '1, '1, '1, '1, '1, 1, '1, '1);
      send_word(mkc_pkg::OP_LOOKUP, '1, 0, 0, 0, 0, 0, 0, 0);
      send_word(mkc_pkg::OP_ADD, 5, 6, 7, 8, 24'h123456, 1, 32'hA5A5A5A5, 32'h5A5A5A5A);
      send_word(mkc_pkg::OP_LOOKUP, 0, 0, 0, 0, 24'h123456, 1, 0, 0);
      send_word(mkc_pkg::OP_LOOKUP, 0, 0, 0, 0, 24'h123456, 0, 0, 0);
      send_word(mkc_pkg::OP_ADD, 9, 0, 0, 0, 24'h00FFFF, 1, 3, 4);
      send_word(mkc_pkg::OP_LOOKUP, 0, 0, 0, 0, 24'h00FFFF, 1, 0, 0);
      send_word(mkc_pkg::OP_LOOKUP, 0, 6, 0, 0, 0, 0, 0, 0);
      send_word(mkc_pkg::OP_LOOKUP, 0, 0, 7, 0, 0, 0, 0, 0);
      send_word(mkc_pkg::OP_LOOKUP, 0, 0, 0, 8, 0, 0, 0, 0);
      send_word(mkc_pkg::OP_ADD, 0, 6, 0, 0, 0, 0, 32'h11, 32'h22);
      send_word(mkc_pkg::OP_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0);
      send_word(mkc_pkg::OP_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0);
      // fill the table so eviction by count and stamp kicks in
      for (int i = 0; i < 36; i++)
         send_word(mkc_pkg::OP_ADD, 32'h100 + i, 0, 0, 0, 0, 0, i, ~i);
      send_word(mkc_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(mkc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      drain();
      for (int n = 0; n < 1600; n++) begin
         random_word();
         if (n == 800) drain();
      end
      drain();
      repeat (4 * (ENTRIES + 2)) @(posedge clock);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
